// ===== rtl/iflr_pkg.sv =====
// shared types and constants for the ipv4 forward route lookup block
`default_nettype none
package iflr_pkg;
  localparam int unsigned RouteEntriesDefault = 64;
  localparam logic [15:0] SumModulus = 16'hffff;
  localparam logic [3:0]  PosMax = 4'hf;
  localparam logic [5:0]  PrefixMax = 6'd32;

  typedef enum logic [1:0] {
    VERDICT_LOCAL   = 2'd0,
    VERDICT_FORWARD = 2'd1,
    VERDICT_TTL     = 2'd2,
    VERDICT_NOROUTE = 2'd3
  } verdict_t;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_HEADER = 1'b1;

  // data handed from cell to cell along the route chain
  typedef struct packed {
    logic        valid;
    logic [31:0] dest;
    logic        found;
    logic [5:0]  best_len;
    logic [31:0] best_hop;
  } probe_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len != 6'd0) begin
      m = 32'hffffffff << (6'd32 - len);
    end
    return m;
  endfunction

  function automatic logic [15:0] add_mod(input logic [15:0] acc, input logic [15:0] half);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, half};
    if (s >= {1'b0, SumModulus}) begin
      s = s - {1'b0, SumModulus};
    end
    return s[15:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/iflr_if.sv =====
// valid/ready channel interfaces for input and result items
`default_nettype none
interface iflr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] route_dest;
  logic [5:0]  route_prefix_len;
  logic [31:0] route_next_hop;
  logic [31:0] header_word;
  logic        header_last;
  modport source (output valid, command, route_dest, route_prefix_len, route_next_hop,
                  header_word, header_last, input ready);
  modport sink (input valid, command, route_dest, route_prefix_len, route_next_hop,
                header_word, header_last, output ready);
endinterface

interface iflr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] next_hop;
  logic [7:0]  new_ttl;
  logic [15:0] new_checksum;
  modport source (output valid, verdict, next_hop, new_ttl, new_checksum, input ready);
  modport sink (input valid, verdict, next_hop, new_ttl, new_checksum, output ready);
endinterface
`default_nettype wire

// ===== rtl/iflr_cell.sv =====
// one route table entry that compares a passing destination and keeps the best match
`default_nettype none
module iflr_cell
  import iflr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [31:0] wr_dest,
  input  wire logic [5:0]  wr_len,
  input  wire logic [31:0] wr_hop,
  input  wire logic        used,
  input  wire probe_t      probe_in,
  output probe_t           probe_out
);
  logic [31:0] dest_r;
  logic [5:0]  len_r;
  logic [31:0] hop_r;
  probe_t      probe_r, probe_nxt;
  logic        hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dest_r <= wr_dest;
      len_r  <= (wr_len > PrefixMax) ? PrefixMax : wr_len;
      hop_r  <= wr_hop;
    end
  end

  assign hit = used && (((probe_in.dest ^ dest_r) & prefix_mask(len_r)) == 32'd0);

  always_comb begin
    probe_nxt = probe_in;
    if (hit && (!probe_in.found || len_r > probe_in.best_len)) begin
      probe_nxt.found    = 1'b1;
      probe_nxt.best_len = len_r;
      probe_nxt.best_hop = hop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_in.valid;
    end
    probe_r.dest     <= probe_nxt.dest;
    probe_r.found    <= probe_nxt.found;
    probe_r.best_len <= probe_nxt.best_len;
    probe_r.best_hop <= probe_nxt.best_hop;
  end

  assign probe_out = probe_r;
endmodule
`default_nettype wire

// ===== rtl/ipv4_forward_route_lookup.sv =====
// top level: header parsing, checksum, route cell chain and result register
// Input items on in_*: command 0 appends a route (prefix, length, next hop),
// command 1 carries one 32-bit header word, header_last closing the packet.
// Header words are taken one per cycle while no lookup or result is pending.
// The last word yields one result on out_*: local, forward with decremented
// ttl, new checksum and next hop, ttl drop, or no-route drop.
// Route lookup runs a probe through a chain of ROUTE_ENTRIES cells, each of
// which registers it, and a closing word's result is registered on out_*
// once the probe leaves the last cell; no input is accepted while a probe
// is in flight or a result is held.
// A route add to a full table is dropped.
// cfg_we writes local_address; write only while the block is idle.
// Reset empties the table, clears per-packet state and local_address.
// A stalled out_ready holds the result and blocks further input.
`default_nettype none
module ipv4_forward_route_lookup
  import iflr_pkg::*;
#(
  parameter int unsigned ROUTE_ENTRIES = RouteEntriesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  iflr_in_if.sink          in_ch,
  iflr_out_if.source       out_ch
);
  localparam int unsigned CW = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  logic [31:0]   local_r;
  logic [CW-1:0] count_r;
  logic [3:0]    pos_r, ihl_r;
  logic [15:0]   sum_r;
  logic [7:0]    ttl_r;
  logic [31:0]   dst_r;
  logic          busy_r;
  logic          ovalid_r;
  logic [1:0]    verdict_r;
  logic [31:0]   hop_r;
  logic [7:0]    nttl_r;
  logic [15:0]   csum_r;
  logic [7:0]    p_ttl_r;
  logic [15:0]   p_sum_r;
  logic [1:0]    p_kind_r;

  logic          acc, add_acc, hdr_acc, last_acc;
  logic [3:0]    ihl_c;
  logic [7:0]    ttl_c;
  logic [31:0]   dst_c;
  logic [15:0]   hi_c, sum_c;
  probe_t        chain [ROUTE_ENTRIES+1];

  assign in_ch.ready = !busy_r && !ovalid_r;
  assign acc      = in_ch.valid && in_ch.ready;
  assign add_acc  = acc && in_ch.command == CMD_ADD;
  assign hdr_acc  = acc && in_ch.command == CMD_HEADER;
  assign last_acc = hdr_acc && in_ch.header_last;

  always_comb begin
    ihl_c = (pos_r == 4'd0) ? in_ch.header_word[27:24] : ihl_r;
    ttl_c = (pos_r == 4'd2) ? in_ch.header_word[31:24] : ttl_r;
    dst_c = (pos_r == 4'd4) ? in_ch.header_word : dst_r;
    hi_c  = in_ch.header_word[31:16];
    if (pos_r == 4'd2) begin
      hi_c = {ttl_c - 8'd1, in_ch.header_word[23:16]};
    end
    sum_c = sum_r;
    if (pos_r < ihl_c) begin
      sum_c = add_mod(sum_c, hi_c);
      if (pos_r != 4'd2) begin
        sum_c = add_mod(sum_c, in_ch.header_word[15:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_r <= '0;
      count_r <= '0;
      pos_r <= '0; ihl_r <= '0; sum_r <= '0; ttl_r <= '0; dst_r <= '0;
      busy_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        local_r <= cfg_wdata;
      end
      if (add_acc && count_r < CW'(ROUTE_ENTRIES)) begin
        count_r <= count_r + 1'b1;
      end
      if (hdr_acc) begin
        if (in_ch.header_last) begin
          pos_r <= '0; ihl_r <= '0; sum_r <= '0; ttl_r <= '0; dst_r <= '0;
        end else begin
          pos_r <= (pos_r < PosMax) ? pos_r + 4'd1 : pos_r;
          ihl_r <= ihl_c; sum_r <= sum_c; ttl_r <= ttl_c; dst_r <= dst_c;
        end
      end
      if (last_acc) begin
        busy_r <= 1'b1;
      end else if (chain[ROUTE_ENTRIES].valid) begin
        busy_r <= 1'b0;
      end
      if (chain[ROUTE_ENTRIES].valid) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // packet verdict held while the probe walks the chain
  always_ff @(posedge clk) begin
    if (last_acc) begin
      p_ttl_r <= ttl_c;
      p_sum_r <= sum_c;
      if (dst_c == local_r) begin
        p_kind_r <= VERDICT_LOCAL;
      end else if (ttl_c == 8'd0) begin
        p_kind_r <= VERDICT_TTL;
      end else begin
        p_kind_r <= VERDICT_FORWARD;
      end
    end
    if (chain[ROUTE_ENTRIES].valid) begin
      verdict_r <= p_kind_r;
      hop_r <= '0; nttl_r <= '0; csum_r <= '0;
      if (p_kind_r == VERDICT_FORWARD) begin
        if (chain[ROUTE_ENTRIES].found) begin
          hop_r  <= chain[ROUTE_ENTRIES].best_hop;
          nttl_r <= p_ttl_r - 8'd1;
          csum_r <= SumModulus - p_sum_r;
        end else begin
          verdict_r <= VERDICT_NOROUTE;
        end
      end
    end
  end

  always_comb begin
    chain[0].valid    = last_acc;
    chain[0].dest     = dst_c;
    chain[0].found    = 1'b0;
    chain[0].best_len = '0;
    chain[0].best_hop = '0;
  end

  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    iflr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (add_acc && count_r[IW-1:0] == IW'(g) && count_r < CW'(ROUTE_ENTRIES)),
      .wr_dest   (in_ch.route_dest),
      .wr_len    (in_ch.route_prefix_len),
      .wr_hop    (in_ch.route_next_hop),
      .used      (count_r > CW'(g)),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1])
    );
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.verdict      = verdict_r;
  assign out_ch.next_hop     = hop_r;
  assign out_ch.new_ttl      = nttl_r;
  assign out_ch.new_checksum = csum_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ch.ready) else $error("input taken during lookup");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ROUTE_ENTRIES)) else $error("route count overflow");
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(verdict_r))
    else $error("result dropped while stalled");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    chain[ROUTE_ENTRIES].valid |-> busy_r && !ovalid_r) else $error("stray probe");
`endif
endmodule
`default_nettype wire
